@@ design/wdll_pkg.sv @@
// Shared constants and codes for the least-loaded worker dispatcher.
package wdll_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int COUNT_BITS  = 16;

  // Fixed field widths of the ports
  localparam int ID_W     = 4;
  localparam int WCOUNT_W = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Internal widths
  localparam int IDX_W = $clog2(MAX_WORKERS);
  localparam int N_W   = $clog2(MAX_WORKERS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [COUNT_BITS-1:0] count_t;

  // Operation codes
  localparam logic OP_ASSIGN  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Policy codes
  localparam logic POLICY_RR = 1'b0;
  localparam logic POLICY_LL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

endpackage

@@ design/worker_dispatch_least_loaded.sv @@
// Top level of the job dispatcher: per-worker load counts, policy pick and update.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+--------------------------
//  input   | in_operation, in_use_preferred, in_worker_id  | start & !busy
//  result  | out_chosen_worker, out_start_worker,          | out_valid, one cycle
//          | out_stop_worker, out_status                   |
//  config  | cfg_we, cfg_index, cfg_wdata                  | cfg_we, no wait
//
// Path: a release or a preferred assign goes from S_IDLE straight to S_UPD, and
// out_valid is registered from S_UPD. A round robin assign first passes S_RRMOD,
// whose subtract loop wraps the pointer into range. A least loaded assign first
// passes S_SCAN, which reads one count a cycle through the single count read port
// and one shared compare.
// Reset (rst_n low at a clock edge) clears all counts, running flags, the round
// robin pointer and the registers (policy 0, sixteen workers).
// The receiver cannot stall: each result shows for exactly one cycle.
module worker_dispatch_least_loaded (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic                          in_use_preferred,
  input  logic [wdll_pkg::ID_W-1:0]     in_worker_id,
  output logic                          out_valid,
  output logic [wdll_pkg::ID_W-1:0]     out_chosen_worker,
  output logic                          out_start_worker,
  output logic                          out_stop_worker,
  output logic [wdll_pkg::STATUS_W-1:0] out_status,
  input  logic                          cfg_we,
  input  logic [wdll_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wdll_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wdll_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RRMOD = 2'd1;  // wrap round robin pointer into range
  localparam logic [1:0] S_SCAN  = 2'd2;  // one count compared per cycle
  localparam logic [1:0] S_UPD   = 2'd3;  // read-modify-write of the chosen count

  logic [1:0]          state_r, state_nxt;

  // Worker state
  count_t              load_r [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] running_r;
  logic [IDX_W-1:0]    next_rr_r, next_rr_nxt;

  // Configuration
  logic                policy_r;
  logic [WCOUNT_W-1:0] wcount_r;

  // Latched transaction
  logic                op_r;
  logic                pref_r;
  logic [ID_W-1:0]     id_r;
  logic [N_W-1:0]      n_r;

  // Working registers
  logic [N_W-1:0]      rr_w_r, rr_w_nxt;
  logic [N_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  count_t              best_val_r, best_val_nxt;
  logic [IDX_W-1:0]    w_r, w_nxt;

  // Result registers
  logic                out_valid_r;
  logic [ID_W-1:0]     out_worker_r;
  logic                out_start_r;
  logic                out_stop_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                accept;
  logic [N_W-1:0]      n_cur;
  logic [IDX_W-1:0]    rd_addr;
  count_t              cnt_rd;
  logic                scan_less;
  logic [IDX_W-1:0]    scan_pick;
  logic                id_bad;

  // Update results
  logic                upd_we;
  count_t              upd_cnt;
  logic                upd_run_we;
  logic                upd_run_val;
  logic [ID_W-1:0]     res_worker;
  logic                res_start;
  logic                res_stop;
  logic [STATUS_W-1:0] res_status;

  // Take a transaction only when not busy
  assign accept = start && !busy;

  // Clamp the worker count into 1..MAX_WORKERS
  always_comb begin
    if (wcount_r == '0) begin
      n_cur = N_W'(1);
    end else if (int'(wcount_r) > MAX_WORKERS) begin
      n_cur = N_W'(MAX_WORKERS);
    end else begin
      n_cur = N_W'(wcount_r);
    end
  end

  // Single read port of the count array
  assign rd_addr   = (state_r == S_SCAN) ? scan_idx_r[IDX_W-1:0] : w_r;
  assign cnt_rd    = load_r[rd_addr];

  // Shared compare of the scan
  assign scan_less = cnt_rd < best_val_r;
  assign scan_pick = scan_less ? scan_idx_r[IDX_W-1:0] : best_idx_r;

  assign id_bad    = int'(id_r) >= int'(n_r);

  // Pointer after a policy pick: the next worker, wrapping at n
  function automatic logic [IDX_W-1:0] rr_after(input logic [IDX_W-1:0] p,
                                                 input logic [N_W-1:0]   n);
    logic [N_W:0] p1;
    p1 = (N_W+1)'(p) + (N_W+1)'(1);
    return (p1 == (N_W+1)'(n)) ? '0 : IDX_W'(p1);
  endfunction

  // Update of the chosen worker
  always_comb begin
    upd_we      = 1'b0;
    upd_cnt     = cnt_rd;
    upd_run_we  = 1'b0;
    upd_run_val = 1'b0;
    res_worker  = ID_W'(w_r);
    res_start   = 1'b0;
    res_stop    = 1'b0;
    res_status  = ST_OK;
    if (op_r == OP_ASSIGN) begin
      if (pref_r && id_bad) begin
        res_worker = id_r;
        res_status = ST_INVALID;
      end else begin
        if (cnt_rd == COUNT_MAX) begin
          res_status = ST_SATURATED;
        end else begin
          upd_we  = 1'b1;
          upd_cnt = cnt_rd + count_t'(1);
        end
        if (!running_r[w_r]) begin
          upd_run_we  = 1'b1;
          upd_run_val = 1'b1;
          res_start   = 1'b1;
        end
      end
    end else begin
      res_worker = id_r;
      if (id_bad || cnt_rd == '0) begin
        res_status = ST_INVALID;
      end else begin
        upd_we  = 1'b1;
        upd_cnt = cnt_rd - count_t'(1);
        if (cnt_rd == count_t'(1)) begin
          upd_run_we  = 1'b1;
          upd_run_val = 1'b0;
          res_stop    = 1'b1;
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    next_rr_nxt  = next_rr_r;
    rr_w_nxt     = rr_w_r;
    scan_idx_nxt = scan_idx_r;
    best_idx_nxt = best_idx_r;
    best_val_nxt = best_val_r;
    w_nxt        = w_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          w_nxt        = IDX_W'(in_worker_id);
          rr_w_nxt     = N_W'(next_rr_r);
          scan_idx_nxt = '0;
          best_idx_nxt = '0;
          best_val_nxt = COUNT_MAX;
          if (in_operation == OP_RELEASE || in_use_preferred) begin
            state_nxt = S_UPD;
          end else if (policy_r == POLICY_LL) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RRMOD;
          end
        end
      end
      S_RRMOD: begin
        if (rr_w_r >= n_r) begin
          rr_w_nxt = rr_w_r - n_r;
        end else begin
          w_nxt       = rr_w_r[IDX_W-1:0];
          next_rr_nxt = rr_after(rr_w_r[IDX_W-1:0], n_r);
          state_nxt   = S_UPD;
        end
      end
      S_SCAN: begin
        best_idx_nxt = scan_pick;
        if (scan_less) begin
          best_val_nxt = cnt_rd;
        end
        scan_idx_nxt = scan_idx_r + N_W'(1);
        if (scan_idx_r == n_r - N_W'(1)) begin
          w_nxt       = scan_pick;
          next_rr_nxt = rr_after(scan_pick, n_r);
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_rr_r   <= '0;
      running_r   <= '0;
      policy_r    <= POLICY_RR;
      wcount_r    <= WCOUNT_W'(16);
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        load_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      next_rr_r   <= next_rr_nxt;
      out_valid_r <= (state_r == S_UPD);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY_MODE:  policy_r <= cfg_wdata[0];
          CFG_WORKER_COUNT: wcount_r <= cfg_wdata[WCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_UPD) begin
        if (upd_we) begin
          load_r[w_r] <= upd_cnt;
        end
        if (upd_run_we) begin
          running_r[w_r] <= upd_run_val;
        end
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    rr_w_r     <= rr_w_nxt;
    scan_idx_r <= scan_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    w_r        <= w_nxt;
    if (accept) begin
      op_r   <= in_operation;
      pref_r <= in_use_preferred;
      id_r   <= in_worker_id;
      n_r    <= n_cur;
    end
    if (state_r == S_UPD) begin
      out_worker_r <= res_worker;
      out_start_r  <= res_start;
      out_stop_r   <= res_stop;
      out_status_r <= res_status;
    end
  end

  assign busy              = (state_r != S_IDLE) || out_valid_r;
  assign out_valid         = out_valid_r;
  assign out_chosen_worker = out_worker_r;
  assign out_start_worker  = out_start_r;
  assign out_stop_worker   = out_stop_r;
  assign out_status        = out_status_r;

endmodule
